### sv/smi_pkg.sv
// ============================================================================
// smi_pkg: shared types and constants of the stack machine executor
// Opcodes, slot format, status codes and the front-to-back queue entry.
// ============================================================================
package smi_pkg;

	typedef enum logic [4:0] {
		OP_HALT, OP_PUSHC, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_RDINT,
		OP_WRINT, OP_RDCHR, OP_WRCHR, OP_PUSHG, OP_POPG, OP_ASF, OP_RSF, OP_PUSHL,
		OP_POPL, OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE, OP_JMP,
		OP_BRF, OP_BRT, OP_CALL, OP_RET, OP_DROP, OP_PUSHR, OP_POPR, OP_DUP
	} op_e;

	localparam logic [1:0] TAG_NUM = 2'd0;
	localparam logic [1:0] TAG_INT = 2'd1;
	localparam logic [1:0] TAG_CHR = 2'd2;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_HALT  = 3'd1;
	localparam logic [2:0] ST_OVFL  = 3'd2;
	localparam logic [2:0] ST_UNFL  = 3'd3;
	localparam logic [2:0] ST_DIVZ  = 3'd4;
	localparam logic [2:0] ST_MODZ  = 3'd5;
	localparam logic [2:0] ST_RANGE = 3'd6;

	typedef struct packed {
		logic [1:0]  tag;
		logic [31:0] val;
	} slot_t;

	// which stack entry the first read fetches
	typedef enum logic [1:0] {
		RS_TOP1, RS_TOP2, RS_FB, RS_LOC
	} rd_sel_e;

	typedef struct packed {
		rd_sel_e rd_sel;
		logic    two_rd;
	} cls_t;

	typedef struct packed {
		op_e         op;
		logic [23:0] imm;
		logic [31:0] rd;
		cls_t        cls;
	} q_item_t;

endpackage

### sv/smi_fe.sv
// ============================================================================
// smi_fe: instruction front end
// Accepts instructions, classifies their stack reads and queues them.
// ============================================================================
module smi_fe import smi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [4:0]  op,
	input  logic [23:0] immediate,
	input  logic signed [31:0] read_value,
	output logic        q_valid,
	output q_item_t     q_item,
	input  logic        q_pop
);

	q_item_t    ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;
	q_item_t    new_item;

	always_comb begin
		new_item.op  = op_e'(op);
		new_item.imm = immediate;
		new_item.rd  = 32'(read_value);
		new_item.cls.two_rd = 1'b0;
		unique case (op_e'(op)) inside
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
			OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE: begin
				new_item.cls.rd_sel = RS_TOP2;
				new_item.cls.two_rd = 1'b1;
			end
			OP_RSF:   new_item.cls.rd_sel = RS_FB;
			OP_PUSHL: new_item.cls.rd_sel = RS_LOC;
			default:  new_item.cls.rd_sel = RS_TOP1;
		endcase
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wp_q] <= new_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (q_pop)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

### sv/smi_div.sv
// ============================================================================
// smi_div: iterative signed divider
// Restoring division, one quotient bit per cycle.
// ============================================================================
module smi_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dvd,
	input  logic [31:0] dvs,
	input  logic        want_mod,
	output logic        done,
	output logic [31:0] res
);

	logic [31:0] rem_q, quo_q, dvs_q;
	logic        na_q, nb_q, mod_q, busy_q, done_q;
	logic [5:0]  cnt_q;
	logic [32:0] shifted;
	logic [33:0] diff;

	assign shifted = {rem_q, quo_q[31]};
	assign diff    = {1'b0, shifted} - {2'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dvd[31] ? 32'd0 - dvd : dvd;
			dvs_q <= dvs[31] ? 32'd0 - dvs : dvs;
			na_q  <= dvd[31];
			nb_q  <= dvs[31];
			mod_q <= want_mod;
		end else if (busy_q) begin
			if (!diff[33]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'd31) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign res  = mod_q ? (na_q ? 32'd0 - rem_q : rem_q)
	                    : ((na_q ^ nb_q) ? 32'd0 - quo_q : quo_q);

endmodule

### sv/smi_be.sv
// ============================================================================
// smi_be: instruction back end
// Reads the stack, executes, commits state and registers the result.
// ============================================================================
module smi_be import smi_pkg::*; #(
	parameter int STACK_DEPTH = 1024,
	parameter int DATA_DEPTH  = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  q_item_t     q_item,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [23:0] next_pc,
	output logic [2:0]  status,
	output logic        write_valid,
	output logic        write_is_char,
	output logic signed [31:0] write_value
);

	localparam int SW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int TW    = $clog2(STACK_DEPTH + 1);
	localparam int DW    = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
	localparam int CLR_N = (STACK_DEPTH > DATA_DEPTH) ? STACK_DEPTH : DATA_DEPTH;
	localparam int CW    = $clog2(CLR_N + 1);

	typedef enum logic [5:0] {
		S_CLR  = 6'b000001,
		S_IDLE = 6'b000010,
		S_R2   = 6'b000100,
		S_EX   = 6'b001000,
		S_DIV  = 6'b010000,
		S_DVF  = 6'b100000
	} state_e;

	state_e   state_q, state_n;
	logic [CW-1:0] clr_q;
	q_item_t  ins_q;
	logic [TW-1:0] top_q, fb_q;
	logic [23:0] pc_q;
	slot_t    ret_q, a_q, stk_rd_q, dat_rd_q;
	logic     stopped_q, ov_q;

	slot_t    stk_mem [STACK_DEPTH];
	slot_t    dat_mem [DATA_DEPTH];

	logic [TW-1:0] ra;
	logic     rd_en, out_free, commit;
	logic [25:0] la_head, la_ex, asf_sum;
	logic     loc_ok, full, empty, lt2, both_int;

	logic [2:0]  st;
	logic [23:0] npc, npc_inc;
	logic        wv, wc, go_div, s_we, d_we;
	logic [31:0] wval, av, bv, alu;
	logic [TW-1:0] s_wa, top_n, fb_n;
	slot_t       s_wd, ret_n;
	logic        div_done;
	logic [31:0] div_res;

	assign la_head = 26'(fb_q) + {{2{q_item.imm[23]}}, q_item.imm};
	assign la_ex   = 26'(fb_q) + {{2{ins_q.imm[23]}}, ins_q.imm};

	// first read from the queue head, second read for two-operand ops
	always_comb begin
		if (state_q == S_R2) begin
			ra = top_q - TW'(1);
		end else begin
			case (q_item.cls.rd_sel)
				RS_TOP2: ra = top_q - TW'(2);
				RS_FB:   ra = fb_q - TW'(1);
				RS_LOC:  ra = la_head[TW-1:0];
				default: ra = top_q - TW'(1);
			endcase
		end
	end

	assign q_pop    = (state_q == S_IDLE) && q_valid;
	assign rd_en    = q_pop || (state_q == S_R2);
	assign out_free = !ov_q || !out_stall;

	assign full     = (top_q == TW'(STACK_DEPTH));
	assign empty    = (top_q == '0);
	assign lt2      = (top_q < TW'(2));
	assign loc_ok   = !la_ex[25] && (la_ex < 26'(STACK_DEPTH));
	assign asf_sum  = 26'(top_q) + 26'd1 + 26'(ins_q.imm);
	assign av       = a_q.val;
	assign bv       = stk_rd_q.val;
	assign both_int = (a_q.tag == TAG_INT) && (stk_rd_q.tag == TAG_INT);
	assign npc_inc  = pc_q + 24'd1;

	always_comb begin
		case (ins_q.op)
			OP_ADD:  alu = av + bv;
			OP_SUB:  alu = av - bv;
			OP_MUL:  alu = av * bv;
			OP_EQ:   alu = {31'd0, av == bv};
			OP_NE:   alu = {31'd0, av != bv};
			OP_LT:   alu = {31'd0, $signed(av) < $signed(bv)};
			OP_LE:   alu = {31'd0, !($signed(bv) < $signed(av))};
			OP_GT:   alu = {31'd0, $signed(bv) < $signed(av)};
			OP_GE:   alu = {31'd0, !($signed(av) < $signed(bv))};
			default: alu = '0;
		endcase
	end

	always_comb begin
		st     = ST_OK;
		npc    = npc_inc;
		wv     = 1'b0;
		wc     = 1'b0;
		wval   = '0;
		s_we   = 1'b0;
		s_wa   = top_q;
		s_wd   = stk_rd_q;
		d_we   = 1'b0;
		top_n  = top_q;
		fb_n   = fb_q;
		ret_n  = ret_q;
		go_div = 1'b0;
		if (stopped_q) begin
			st  = ST_HALT;
			npc = pc_q;
		end else if (state_q == S_DVF) begin
			s_we  = 1'b1;
			s_wa  = top_q - TW'(2);
			s_wd  = {TAG_INT, div_res};
			top_n = top_q - TW'(1);
		end else begin
			unique case (ins_q.op) inside
				OP_HALT: st = ST_HALT;
				OP_PUSHC, OP_RDINT, OP_RDCHR, OP_PUSHR, OP_CALL: begin
					if (full) begin
						st = ST_OVFL;
					end else begin
						s_we  = 1'b1;
						top_n = top_q + TW'(1);
						case (ins_q.op)
							OP_PUSHC: s_wd = {TAG_INT, {{8{ins_q.imm[23]}}, ins_q.imm}};
							OP_RDINT: s_wd = {TAG_INT, ins_q.rd};
							OP_RDCHR: s_wd = {TAG_CHR, 24'd0, ins_q.rd[7:0]};
							OP_PUSHR: s_wd = {TAG_INT, ret_q.val};
							default: begin
								s_wd = {TAG_INT, 8'd0, npc_inc};
								npc  = ins_q.imm;
							end
						endcase
					end
				end
				OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
					if (lt2) begin
						st = ST_UNFL;
					end else if (!both_int) begin
						top_n = top_q - TW'(2);
					end else if (ins_q.op == OP_DIV && bv == '0) begin
						st = ST_DIVZ;
					end else if (ins_q.op == OP_MOD && bv == '0) begin
						st = ST_MODZ;
					end else if (ins_q.op == OP_DIV || ins_q.op == OP_MOD) begin
						go_div = 1'b1;
					end else begin
						s_we  = 1'b1;
						s_wa  = top_q - TW'(2);
						s_wd  = {TAG_INT, alu};
						top_n = top_q - TW'(1);
					end
				end
				OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE: begin
					if (lt2) begin
						st = ST_UNFL;
					end else begin
						s_we  = 1'b1;
						s_wa  = top_q - TW'(2);
						s_wd  = {TAG_INT, alu};
						top_n = top_q - TW'(1);
					end
				end
				OP_WRINT, OP_WRCHR: begin
					if (empty) begin
						st = ST_UNFL;
					end else begin
						wv    = 1'b1;
						wc    = (ins_q.op == OP_WRCHR);
						wval  = wc ? {24'd0, bv[7:0]} : bv;
						top_n = top_q - TW'(1);
					end
				end
				OP_PUSHG: begin
					if (25'(ins_q.imm) >= 25'(DATA_DEPTH)) begin
						st = ST_RANGE;
					end else if (full) begin
						st = ST_OVFL;
					end else begin
						s_we  = 1'b1;
						s_wd  = {TAG_INT, dat_rd_q.val};
						top_n = top_q + TW'(1);
					end
				end
				OP_POPG: begin
					if (empty) begin
						st = ST_UNFL;
					end else if (25'(ins_q.imm) >= 25'(DATA_DEPTH)) begin
						st = ST_RANGE;
					end else begin
						d_we  = 1'b1;
						top_n = top_q - TW'(1);
					end
				end
				OP_ASF: begin
					if (asf_sum > 26'(STACK_DEPTH)) begin
						st = ST_OVFL;
					end else begin
						s_we  = 1'b1;
						s_wd  = {TAG_NUM, 32'(fb_q)};
						fb_n  = top_q + TW'(1);
						top_n = asf_sum[TW-1:0];
					end
				end
				OP_RSF: begin
					if (fb_q == '0) begin
						st = ST_UNFL;
					end else if (bv > 32'(STACK_DEPTH)) begin
						st = ST_RANGE;
					end else begin
						top_n = fb_q - TW'(1);
						fb_n  = bv[TW-1:0];
					end
				end
				OP_PUSHL: begin
					if (!loc_ok) begin
						st = ST_RANGE;
					end else if (full) begin
						st = ST_OVFL;
					end else begin
						s_we  = 1'b1;
						top_n = top_q + TW'(1);
					end
				end
				OP_POPL: begin
					if (empty) begin
						st = ST_UNFL;
					end else if (!loc_ok) begin
						st = ST_RANGE;
					end else begin
						s_we  = 1'b1;
						s_wa  = la_ex[TW-1:0];
						top_n = top_q - TW'(1);
					end
				end
				OP_JMP: npc = ins_q.imm;
				OP_BRF, OP_BRT: begin
					if (empty) begin
						st = ST_UNFL;
					end else begin
						top_n = top_q - TW'(1);
						if (bv == ((ins_q.op == OP_BRF) ? 32'd0 : 32'd1))
							npc = ins_q.imm;
					end
				end
				OP_RET: begin
					if (empty) begin
						st = ST_UNFL;
					end else begin
						npc   = bv[23:0];
						top_n = top_q - TW'(1);
					end
				end
				OP_DROP: begin
					if ({1'b0, ins_q.imm} > 25'(top_q))
						st = ST_UNFL;
					else
						top_n = top_q - ins_q.imm[TW-1:0];
				end
				OP_POPR: begin
					if (empty) begin
						st = ST_UNFL;
					end else begin
						ret_n = stk_rd_q;
						top_n = top_q - TW'(1);
					end
				end
				OP_DUP: begin
					if (empty) begin
						st = ST_UNFL;
					end else if (full) begin
						st = ST_OVFL;
					end else begin
						s_we  = 1'b1;
						top_n = top_q + TW'(1);
					end
				end
				default: st = ST_HALT;
			endcase
		end
	end

	assign commit = out_free && (((state_q == S_EX) && !go_div) || (state_q == S_DVF));

	smi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    ((state_q == S_EX) && go_div),
		.dvd      (av),
		.dvs      (bv),
		.want_mod (ins_q.op == OP_MOD),
		.done     (div_done),
		.res      (div_res)
	);

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_CLR:  if (clr_q == CW'(CLR_N - 1)) state_n = S_IDLE;
			S_IDLE: if (q_valid) state_n = q_item.cls.two_rd ? S_R2 : S_EX;
			S_R2:   state_n = S_EX;
			S_EX:   if (go_div) state_n = S_DIV;
			        else if (commit) state_n = S_IDLE;
			S_DIV:  if (div_done) state_n = S_DVF;
			S_DVF:  if (commit) state_n = S_IDLE;
			default: state_n = S_CLR;
		endcase
	end

	// memories: clearing pass after reset, then commits
	always_ff @(posedge clk) begin
		if (state_q == S_CLR) begin
			if (clr_q < CW'(STACK_DEPTH))
				stk_mem[clr_q[SW-1:0]] <= '0;
			if (clr_q < CW'(DATA_DEPTH))
				dat_mem[clr_q[DW-1:0]] <= '0;
		end else if (commit && st == ST_OK) begin
			if (s_we)
				stk_mem[s_wa[SW-1:0]] <= s_wd;
			if (d_we)
				dat_mem[ins_q.imm[DW-1:0]] <= stk_rd_q;
		end
		if (rd_en)
			stk_rd_q <= stk_mem[ra[SW-1:0]];
		if (q_pop)
			dat_rd_q <= dat_mem[q_item.imm[DW-1:0]];
		if (q_pop)
			ins_q <= q_item;
		if (state_q == S_R2)
			a_q <= stk_rd_q;
		if (commit) begin
			next_pc       <= npc;
			status        <= st;
			write_valid   <= wv;
			write_is_char <= wc;
			write_value   <= $signed(wval);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			top_q     <= '0;
			fb_q      <= '0;
			pc_q      <= '0;
			ret_q     <= '0;
			stopped_q <= 1'b0;
			ov_q      <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == S_CLR)
				clr_q <= clr_q + CW'(1);
			if (commit) begin
				pc_q <= npc;
				if (st == ST_OK) begin
					top_q <= top_n;
					fb_q  <= fb_n;
					ret_q <= ret_n;
				end else begin
					stopped_q <= 1'b1;
				end
			end
			if (commit)
				ov_q <= 1'b1;
			else if (!out_stall)
				ov_q <= 1'b0;
		end
	end

	assign out_valid = ov_q;

endmodule

### sv/stack_machine_instruction_executor.sv
// ============================================================================
// stack_machine_instruction_executor: 32-bit tagged stack machine executor
// Executes one instruction per transaction and reports next pc and status.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall) carries one instruction: opcode,
//   24-bit immediate and the value consumed by rdint and rdchr. Output
//   channel (out_valid / out_stall) returns next_pc, status and an optional
//   integer or character write, one transaction per instruction, in order.
//   A two-entry queue decouples accept from execution, so instructions are
//   taken while the back end works or a result waits.
//   The back end takes an instruction from the queue, reads the stack,
//   executes and registers the result; two-operand arithmetic and
//   compares make two reads through the single stack read port, and
//   div and mod go through the 32-step iterative divider. The back end
//   takes no new instruction from the queue until the current one has
//   committed its result.
//   Reset: a clearing pass zeroes every entry of the stack and data
//   memories; the queue fills but nothing executes meanwhile.
//   When out_stall is high the pending result holds and the back end waits
//   with its next result; the queue then stalls the sender once full.
//   Halt and every error are terminal: later instructions report status 1.
// ============================================================================
module stack_machine_instruction_executor import smi_pkg::*; #(
	parameter int STACK_DEPTH = 1024,
	parameter int DATA_DEPTH  = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [4:0]  op,
	input  logic [23:0] immediate,
	input  logic signed [31:0] read_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [23:0] next_pc,
	output logic [2:0]  status,
	output logic        write_valid,
	output logic        write_is_char,
	output logic signed [31:0] write_value
);

	logic    q_valid, q_pop;
	q_item_t q_item;

	// accept and classify
	smi_fe u_fe (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.immediate  (immediate),
		.read_value (read_value),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	// execute, commit and hold the result until taken
	smi_be #(
		.STACK_DEPTH (STACK_DEPTH),
		.DATA_DEPTH  (DATA_DEPTH)
	) u_be (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.next_pc       (next_pc),
		.status        (status),
		.write_valid   (write_valid),
		.write_is_char (write_is_char),
		.write_value   (write_value)
	);

endmodule

### dv/stack_machine_instruction_executor_chk.sv
`timescale 1ns / 1ps
// ============================================================================
// stack_machine_instruction_executor_chk: result checker for the executor
// Watches both channels, runs its own model of the machine on every accepted
// instruction and compares each returned transaction field by field.
// ============================================================================
module stack_machine_instruction_executor_chk import smi_pkg::*; #(
	parameter int STACK_DEPTH = 1024,
	parameter int DATA_DEPTH  = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [4:0]  op,
	input  logic [23:0] immediate,
	input  logic [31:0] read_value,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [23:0] next_pc,
	input  logic [2:0]  status,
	input  logic        write_valid,
	input  logic        write_is_char,
	input  logic [31:0] write_value,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [23:0] pc;
		logic [2:0]  st;
		logic        wv;
		logic        wc;
		logic [31:0] wval;
	} exec_result_t;

	exec_result_t outcome_q[$];

	slot_t       stk [STACK_DEPTH];
	slot_t       dat [DATA_DEPTH];
	int unsigned sp;
	int unsigned fbase;
	logic [23:0] pc_r;
	slot_t       ret_r;
	bit          stopped;

	initial begin
		foreach (stk[i]) stk[i] = '0;
		foreach (dat[i]) dat[i] = '0;
		sp = 0;
		fbase = 0;
		pc_r = '0;
		ret_r = '0;
		stopped = 0;
		fail_count = 0;
		pending = 0;
	end

	function automatic logic [2:0] room(int unsigned pops, int unsigned pushes);
		if (sp < pops)
			return ST_UNFL;
		if (sp - pops + pushes > STACK_DEPTH)
			return ST_OVFL;
		return ST_OK;
	endfunction

	function automatic void push_slot(slot_t s);
		stk[sp] = s;
		sp++;
	endfunction

	function automatic slot_t pop_slot();
		sp--;
		return stk[sp];
	endfunction

	// signed divide by magnitudes, so min / -1 wraps to min
	function automatic logic [31:0] sdivmod(logic [31:0] a, logic [31:0] b, bit want_mod);
		logic [31:0] ma;
		logic [31:0] mb;
		logic [31:0] q;
		logic [31:0] r;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		r = ma % mb;
		if (want_mod)
			return a[31] ? -r : r;
		return (a[31] ^ b[31]) ? -q : q;
	endfunction

	function automatic exec_result_t execute(op_e o, logic [23:0] imm, logic [31:0] rd);
		exec_result_t res;
		logic [23:0]  npc;
		logic [2:0]   st;
		logic [31:0]  simm;
		logic [31:0]  a;
		logic [31:0]  b;
		logic [31:0]  v;
		slot_t        l;
		slot_t        r;
		longint       addr;
		bit           c;
		res = '0;
		if (stopped) begin
			res.pc = pc_r;
			res.st = ST_HALT;
			return res;
		end
		npc = pc_r + 24'd1;
		st = ST_OK;
		simm = {{8{imm[23]}}, imm};
		case (o)
			OP_HALT: st = ST_HALT;
			OP_PUSHC: begin
				st = room(0, 1);
				if (st == ST_OK) push_slot({TAG_INT, simm});
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
				st = room(2, 1);
				if (st == ST_OK) begin
					r = stk[sp - 1];
					l = stk[sp - 2];
					if (l.tag == TAG_INT && r.tag == TAG_INT) begin
						a = l.val;
						b = r.val;
						if (o == OP_DIV && b == 0)
							st = ST_DIVZ;
						else if (o == OP_MOD && b == 0)
							st = ST_MODZ;
						else begin
							case (o)
								OP_ADD: v = a + b;
								OP_SUB: v = a - b;
								OP_MUL: v = a * b;
								default: v = sdivmod(a, b, o == OP_MOD);
							endcase
							sp -= 2;
							push_slot({TAG_INT, v});
						end
					end else
						sp -= 2;	// non-integer operands: consume, push nothing
				end
			end
			OP_RDINT: begin
				st = room(0, 1);
				if (st == ST_OK) push_slot({TAG_INT, rd});
			end
			OP_RDCHR: begin
				st = room(0, 1);
				if (st == ST_OK) push_slot({TAG_CHR, 24'd0, rd[7:0]});
			end
			OP_WRINT, OP_WRCHR: begin
				st = room(1, 0);
				if (st == ST_OK) begin
					l = pop_slot();
					res.wval = l.val;
					res.wv = 1'b1;
					if (o == OP_WRCHR) begin
						res.wc = 1'b1;
						res.wval = {24'd0, res.wval[7:0]};
					end
				end
			end
			OP_PUSHG: begin
				if (imm >= DATA_DEPTH)
					st = ST_RANGE;
				else begin
					st = room(0, 1);
					if (st == ST_OK) push_slot({TAG_INT, dat[imm].val});
				end
			end
			OP_POPG: begin
				st = room(1, 0);
				if (st == ST_OK) begin
					if (imm >= DATA_DEPTH)
						st = ST_RANGE;
					else
						dat[imm] = pop_slot();
				end
			end
			OP_ASF: begin
				if (sp + 1 + imm > STACK_DEPTH)
					st = ST_OVFL;
				else begin
					push_slot({TAG_NUM, 32'(fbase)});
					fbase = sp;
					sp += imm;
				end
			end
			OP_RSF: begin
				if (fbase == 0)
					st = ST_UNFL;
				else begin
					r = stk[fbase - 1];
					if (r.val > STACK_DEPTH)
						st = ST_RANGE;
					else begin
						sp = fbase - 1;
						fbase = r.val;
					end
				end
			end
			OP_PUSHL, OP_POPL: begin
				addr = longint'(fbase) + longint'($signed(simm));
				if (o == OP_POPL && sp == 0)
					st = ST_UNFL;
				else if (addr < 0 || addr >= STACK_DEPTH)
					st = ST_RANGE;
				else if (o == OP_PUSHL) begin
					st = room(0, 1);
					if (st == ST_OK) push_slot(stk[addr]);
				end else
					stk[addr] = pop_slot();
			end
			OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE: begin
				st = room(2, 1);
				if (st == ST_OK) begin
					r = pop_slot();
					l = pop_slot();
					case (o)
						OP_EQ: c = l.val == r.val;
						OP_NE: c = l.val != r.val;
						OP_LT: c = $signed(l.val) < $signed(r.val);
						OP_LE: c = !($signed(r.val) < $signed(l.val));
						OP_GT: c = $signed(r.val) < $signed(l.val);
						default: c = !($signed(l.val) < $signed(r.val));
					endcase
					push_slot({TAG_INT, 31'd0, c});
				end
			end
			OP_JMP: npc = imm;
			OP_BRF, OP_BRT: begin
				st = room(1, 0);
				if (st == ST_OK) begin
					r = pop_slot();
					if (r.val == ((o == OP_BRF) ? 32'd0 : 32'd1)) npc = imm;
				end
			end
			OP_CALL: begin
				st = room(0, 1);
				if (st == ST_OK) begin
					push_slot({TAG_INT, 8'd0, npc});
					npc = imm;
				end
			end
			OP_RET: begin
				st = room(1, 0);
				if (st == ST_OK) begin
					r = pop_slot();
					npc = r.val[23:0];
				end
			end
			OP_DROP: begin
				if (imm > sp)
					st = ST_UNFL;
				else
					sp -= imm;
			end
			OP_PUSHR: begin
				st = room(0, 1);
				if (st == ST_OK) push_slot({TAG_INT, ret_r.val});
			end
			OP_POPR: begin
				st = room(1, 0);
				if (st == ST_OK) ret_r = pop_slot();
			end
			default: begin
				st = room(1, 2);
				if (st == ST_OK) push_slot(stk[sp - 1]);
			end
		endcase
		if (st != ST_OK) begin
			stopped = 1;
			res.wv = 0;
			res.wc = 0;
			res.wval = '0;
		end
		pc_r = npc;
		res.pc = npc;
		res.st = st;
		return res;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		exec_result_t want;
		if (arst_n && in_valid && !in_stall)
			outcome_q.push_back(execute(op_e'(op), immediate, read_value));
		if (arst_n && out_valid && !out_stall) begin
			if (outcome_q.size() == 0) begin
				$display("%0t: result with nothing expected, next_pc 0x%0h status %0d",
					$time, next_pc, status);
				fail_count++;
			end else begin
				want = outcome_q.pop_front();
				check_field("next_pc", want.pc, next_pc);
				check_field("status", want.st, status);
				check_field("write_valid", want.wv, write_valid);
				check_field("write_is_char", want.wc, write_is_char);
				check_field("write_value", want.wval, write_value);
			end
		end
		pending = outcome_q.size();
	end

endmodule

### dv/stack_machine_instruction_executor_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// stack_machine_instruction_executor_tb: top of the executor testbench
// Drives instruction programs that stay clear of terminal errors until one
// chosen fault at the end, with bursty input and a stalling receiver.
// ============================================================================
module stack_machine_instruction_executor_tb;
	import smi_pkg::*;

	localparam int STACK_DEPTH = 1024;
	localparam int DATA_DEPTH  = 256;
	localparam int N_RANDOM    = 1420;
	localparam int STACK_CAP   = 1000;	// keep well below overflow in random programs
	localparam int IDLE_LIMIT  = 4000;	// covers the clearing pass and the long hold-off

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [4:0]  op;
	logic [23:0] immediate;
	logic signed [31:0] read_value;
	logic        out_valid;
	logic        out_stall;
	logic [23:0] next_pc;
	logic [2:0]  status;
	logic        write_valid;
	logic        write_is_char;
	logic signed [31:0] write_value;
	int          fail_count;
	int          pending;

	// stimulus-side view of the stack: tags and a known-nonzero flag per slot,
	// enough to keep random programs away from traps
	logic [1:0]  sh_tag [STACK_DEPTH];
	bit          sh_nz  [STACK_DEPTH];
	int          sd;
	int          fb;
	int          floor_sp;
	int          frame_q[$];
	bit          frozen;
	int          sent;
	int          burst_left;
	bit          hold_done;

	stack_machine_instruction_executor #(
		.STACK_DEPTH(STACK_DEPTH),
		.DATA_DEPTH (DATA_DEPTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.immediate    (immediate),
		.read_value   (read_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.next_pc      (next_pc),
		.status       (status),
		.write_valid  (write_valid),
		.write_is_char(write_is_char),
		.write_value  (write_value)
	);

	stack_machine_instruction_executor_chk #(
		.STACK_DEPTH(STACK_DEPTH),
		.DATA_DEPTH (DATA_DEPTH)
	) i_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.immediate    (immediate),
		.read_value   (read_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.next_pc      (next_pc),
		.status       (status),
		.write_valid  (write_valid),
		.write_is_char(write_is_char),
		.write_value  (write_value),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: end the run if neither channel moves a transaction for too long
	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle = 0;
			else
				idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Receiver: phases of differing stall density, plus one long hold-off once
	// enough traffic has flowed so the internal queue fills and stalls the sender
	initial begin
		int phase_len;
		int density;
		out_stall <= 1'b0;
		hold_done = 0;
		@(posedge arst_n);
		forever begin
			if (!hold_done && sent >= 300) begin
				hold_done = 1;
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
			end
			phase_len = $urandom_range(20, 80);
			case ($urandom_range(0, 2))
				0: density = 0;
				1: density = 25;
				default: density = 60;
			endcase
			repeat (phase_len) begin
				out_stall <= ($urandom_range(0, 99) < density);
				@(posedge clk);
			end
		end
	end

	function automatic void push_sh(logic [1:0] tag, bit nz);
		sh_tag[sd] = tag;
		sh_nz[sd] = nz;
		sd++;
	endfunction

	// Advance the stimulus-side stack view by one accepted instruction
	function automatic void track(op_e o, logic [23:0] imm, logic [31:0] rd);
		int addr;
		logic [1:0] tl;
		logic [1:0] tr;
		if (frozen)
			return;
		case (o)
			OP_PUSHC: push_sh(TAG_INT, imm != 0);
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
				tr = sh_tag[sd - 1];
				tl = sh_tag[sd - 2];
				sd -= 2;
				if (tl == TAG_INT && tr == TAG_INT) push_sh(TAG_INT, 0);
			end
			OP_RDINT: push_sh(TAG_INT, rd != 0);
			OP_RDCHR: push_sh(TAG_CHR, rd[7:0] != 0);
			OP_WRINT, OP_WRCHR, OP_POPG, OP_BRF, OP_BRT, OP_RET, OP_POPR: sd--;
			OP_PUSHG, OP_PUSHR, OP_CALL: push_sh(TAG_INT, 0);
			OP_ASF: begin
				frame_q.push_back(floor_sp);
				frame_q.push_back(fb);
				push_sh(TAG_NUM, 0);
				fb = sd;
				sd = fb + int'(imm);
				floor_sp = sd;
			end
			OP_RSF: begin
				sd = fb - 1;
				fb = frame_q.pop_back();
				floor_sp = frame_q.pop_back();
			end
			OP_PUSHL: begin
				addr = fb + int'($signed(imm));
				push_sh(sh_tag[addr], sh_nz[addr]);
			end
			OP_POPL: begin
				addr = fb + int'($signed(imm));
				sd--;
				sh_tag[addr] = sh_tag[sd];
				sh_nz[addr] = sh_nz[sd];
			end
			OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE: begin
				sd -= 2;
				push_sh(TAG_INT, 0);
			end
			OP_DROP: sd -= int'(imm);
			OP_DUP: push_sh(sh_tag[sd - 1], sh_nz[sd - 1]);
			default: ;
		endcase
	endfunction

	// Offer one instruction, hold it until accepted; gaps fall between bursts
	task automatic issue(op_e o, logic [23:0] imm, logic [31:0] rd);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		op <= o;
		immediate <= imm;
		read_value <= rd;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
		track(o, imm, rd);
	endtask

	// Pick a random instruction that cannot trap given the current stack view
	task automatic random_item();
		op_e         o;
		logic [23:0] imm;
		logic [31:0] rd;
		int          avail;
		bit          ok;
		ok = 0;
		while (!ok) begin
			avail = sd - floor_sp;
			o = op_e'($urandom_range(1, 31));
			imm = 24'($urandom());
			rd = $urandom();
			case (o)
				OP_PUSHC, OP_RDINT, OP_RDCHR, OP_PUSHR, OP_CALL: ok = sd < STACK_CAP;
				OP_PUSHG: begin
					imm = 24'($urandom_range(0, DATA_DEPTH - 1));
					ok = sd < STACK_CAP;
				end
				OP_POPG: begin
					imm = 24'($urandom_range(0, DATA_DEPTH - 1));
					ok = avail >= 1;
				end
				OP_ADD, OP_SUB, OP_MUL, OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE:
					ok = avail >= 2;
				OP_DIV, OP_MOD:
					ok = avail >= 2 && !(sh_tag[sd - 1] == TAG_INT &&
						sh_tag[sd - 2] == TAG_INT && !sh_nz[sd - 1]);
				OP_WRINT, OP_WRCHR, OP_BRF, OP_BRT, OP_RET, OP_POPR: ok = avail >= 1;
				OP_ASF: begin
					imm = 24'($urandom_range(0, 8));
					ok = sd + 1 + int'(imm) <= STACK_CAP;
				end
				OP_RSF: ok = frame_q.size() != 0;
				OP_PUSHL: begin
					ok = sd > 0 && sd < STACK_CAP;
					if (ok) imm = 24'($urandom_range(0, sd - 1) - fb);
				end
				OP_POPL: begin
					ok = avail >= 1 && floor_sp > fb;
					if (ok) imm = 24'($urandom_range(0, floor_sp - fb - 1));
				end
				OP_DROP:
					imm = 24'($urandom_range(0, (sd > 600 || avail < 4) ? avail : 4));
				OP_DUP: ok = avail >= 1 && sd < STACK_CAP;
				OP_JMP: ok = 1;
				default: ok = 0;
			endcase
			if (o == OP_DROP) ok = 1;
		end
		issue(o, imm, rd);
	endtask

	initial begin
		foreach (sh_tag[i]) begin
			sh_tag[i] = TAG_NUM;
			sh_nz[i] = 0;
		end
		sd = 0;
		fb = 0;
		floor_sp = 0;
		frozen = 0;
		sent = 0;
		burst_left = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		op <= OP_HALT;
		immediate <= '0;
		read_value <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: immediate extremes, signed wrap in div and mod, tagged
		// operands, frames, branches, pc wrap, the return register
		issue(OP_PUSHC, 24'h7FFFFF, '0);
		issue(OP_PUSHC, 24'h800000, '0);
		issue(OP_ADD, 24'hFFFFFF, 32'hFFFFFFFF);
		issue(OP_PUSHC, 24'hFFFFFF, '0);
		issue(OP_MUL, '0, '0);
		issue(OP_RDINT, '0, 32'h80000000);
		issue(OP_PUSHC, 24'hFFFFFF, '0);
		issue(OP_DIV, '0, '0);
		issue(OP_RDINT, '0, 32'h80000000);
		issue(OP_PUSHC, 24'hFFFFFF, '0);
		issue(OP_MOD, '0, '0);
		issue(OP_WRINT, '0, '0);
		issue(OP_WRINT, '0, '0);
		issue(OP_RDCHR, '0, 32'hFFFFFFFF);
		issue(OP_ADD, '0, '0);		// integer plus character: nothing pushed
		issue(OP_RDCHR, '0, 32'h00000141);
		issue(OP_WRCHR, '0, '0);
		issue(OP_PUSHG, 24'(DATA_DEPTH - 1), '0);
		issue(OP_POPG, '0, '0);
		issue(OP_ASF, 24'd3, '0);
		issue(OP_PUSHC, 24'd9, '0);
		issue(OP_POPL, 24'd2, '0);
		issue(OP_PUSHL, 24'hFFFFFF, '0);	// reads the saved frame base slot
		issue(OP_RSF, '0, '0);
		issue(OP_PUSHC, 24'd1, '0);
		issue(OP_BRT, 24'hFFFFFF, '0);
		issue(OP_JMP, 24'hFFFFFF, '0);		// next instruction wraps pc to zero
		issue(OP_CALL, 24'h123456, '0);
		issue(OP_POPR, '0, '0);
		issue(OP_PUSHR, '0, '0);
		issue(OP_DUP, '0, '0);
		issue(OP_LE, '0, '0);
		issue(OP_BRF, 24'h000010, '0);

		repeat (N_RANDOM) random_item();

		// Finish with one terminal fault, then show that later work is refused
		case ($urandom_range(0, 5))
			0: issue(OP_HALT, '0, '0);
			1: begin
				issue(OP_PUSHC, 24'd5, '0);
				issue(OP_PUSHC, 24'd0, '0);
				issue(OP_DIV, '0, '0);
			end
			2: begin
				issue(OP_PUSHC, 24'd5, '0);
				issue(OP_PUSHC, 24'd0, '0);
				issue(OP_MOD, '0, '0);
			end
			3: issue(OP_PUSHG, 24'($urandom_range(DATA_DEPTH, 24'hFFFFFF)), '0);
			4: issue(OP_DROP, 24'(sd + 1), '0);
			default: issue(OP_ASF, 24'(STACK_DEPTH), '0);
		endcase
		frozen = 1;
		repeat (6) issue(op_e'($urandom_range(0, 31)), 24'($urandom()), $urandom());
		in_valid <= 1'b0;

		// Drain until every expected result has been checked, then idle before reporting
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### filelist.f
sv/smi_pkg.sv
sv/smi_fe.sv
sv/smi_div.sv
sv/smi_be.sv
sv/stack_machine_instruction_executor.sv
dv/stack_machine_instruction_executor_chk.sv
dv/stack_machine_instruction_executor_tb.sv
